// ===== hw/rtl/sdhp_pkg.sv =====
// Shared types and constants for the signed decimal/hex integer parser.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package sdhp_pkg;

    localparam int unsigned MAX_LEN_DEF = 255;

    // One character word on the input channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    // One result word on the output channel.
    typedef struct packed {
        logic               ok;
        logic signed [63:0] value;
        logic [7:0]         consumed;
        logic               overflow;
    } t_out;

    // Classified character, as queued between the front and back ends.
    typedef struct packed {
        logic       is_minus;
        logic       is_x;
        logic       is_zero;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
        logic       last;
    } t_cls;

endpackage

`default_nettype wire

// ===== hw/rtl/sdhp_front.sv =====
// Front end: accepts character words, classifies them and queues the class records.
// Depends on sdhp_pkg for the input word and class record types.
`default_nettype none

module sdhp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire sdhp_pkg::t_in i_in_data,
    output logic               o_in_stall,
    output logic               o_cls_valid,
    output sdhp_pkg::t_cls     o_cls,
    input  wire logic          i_pop
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned PW     = $clog2(QDEPTH);
    localparam int unsigned CW     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    sdhp_pkg::t_cls r_q [QDEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;

    sdhp_pkg::t_cls w_cls;
    logic           w_push;
    logic           w_pop;
    logic           w_dec;
    logic           w_uhex;
    logic [7:0]     w_off;

    always_comb begin
        w_dec  = (i_in_data.ch >= CH_0) && (i_in_data.ch <= CH_9);
        w_uhex = (i_in_data.ch >= CH_A) && (i_in_data.ch <= CH_F);
        // Letters A-F map to 10-15.
        w_off  = w_dec ? (i_in_data.ch - CH_0) : (i_in_data.ch - CH_A + 8'd10);
        w_cls.is_minus = (i_in_data.ch == CH_MINUS);
        w_cls.is_x     = (i_in_data.ch == CH_X);
        w_cls.is_zero  = (i_in_data.ch == CH_0);
        w_cls.is_dec   = w_dec;
        w_cls.is_hex   = w_dec || w_uhex;
        w_cls.digit    = w_off[3:0];
        w_cls.last     = i_in_data.last;
    end

    assign o_in_stall  = (r_cnt == CW'(QDEPTH));
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cls_valid = (r_cnt != '0);
    assign w_pop       = i_pop && o_cls_valid;
    assign o_cls       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdhp_back.sv =====
// Back end: parse state machine, magnitude and signed accumulators, result register.
// Depends on sdhp_pkg for the class record and result word types.
`default_nettype none

module sdhp_back #(
    parameter int unsigned MAX_LEN = sdhp_pkg::MAX_LEN_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cls_valid,
    input  wire sdhp_pkg::t_cls i_cls,
    output logic                o_pop,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output sdhp_pkg::t_out      o_out_data
);

    localparam int unsigned CW  = $clog2(MAX_LEN + 1);
    localparam int unsigned CWX = (CW > 8) ? CW : 8;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEAD,
        PH_ZERO,
        PH_HEX0,
        PH_DEC,
        PH_HEX,
        PH_DONE
    } t_phase;

    t_phase         r_phase;
    t_phase         n_phase;
    logic [63:0]    r_acc;
    logic [63:0]    n_acc;
    logic [63:0]    r_sval;
    logic [63:0]    n_sval;
    logic           r_neg;
    logic           n_neg;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic           r_wrap;
    logic           n_wrap;
    logic           r_ov;
    sdhp_pkg::t_out r_out;
    sdhp_pkg::t_out n_out;

    logic           w_dig;
    logic           w_b16;
    logic           w_bump;
    logic           w_set_neg;
    logic           w_fin;
    logic           w_fin_ok;
    logic [67:0]    w_magx;
    logic [67:0]    w_dx;
    logic [67:0]    w_mac;
    logic [63:0]    w_sdig;
    logic [63:0]    w_smac;
    logic [CW-1:0]  w_cnt_inc;
    logic [CWX-1:0] w_cnt_ext;

    assign o_pop = i_cls_valid && (!r_ov || !i_out_stall);

    // Next phase and the actions of this character.
    always_comb begin
        n_phase   = r_phase;
        w_dig     = 1'b0;
        w_b16     = 1'b0;
        w_bump    = 1'b0;
        w_set_neg = 1'b0;
        w_fin     = 1'b0;
        w_fin_ok  = 1'b0;
        unique case (r_phase)
            PH_START, PH_LEAD: begin
                if (r_phase == PH_START && i_cls.is_minus) begin
                    w_set_neg = 1'b1;
                    w_bump    = 1'b1;
                    n_phase   = PH_LEAD;
                    w_fin     = i_cls.last;
                end else if (i_cls.is_dec) begin
                    w_dig    = 1'b1;
                    w_bump   = 1'b1;
                    n_phase  = i_cls.is_zero ? PH_ZERO : PH_DEC;
                    w_fin    = i_cls.last;
                    w_fin_ok = 1'b1;
                end else begin
                    w_fin   = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            PH_ZERO, PH_DEC: begin
                if (r_phase == PH_ZERO && i_cls.is_x) begin
                    w_bump  = 1'b1;
                    n_phase = PH_HEX0;
                    w_fin   = i_cls.last;
                end else if (i_cls.is_dec) begin
                    w_dig    = 1'b1;
                    w_bump   = 1'b1;
                    n_phase  = PH_DEC;
                    w_fin    = i_cls.last;
                    w_fin_ok = 1'b1;
                end else begin
                    w_fin    = 1'b1;
                    w_fin_ok = 1'b1;
                    n_phase  = PH_DONE;
                end
            end
            PH_HEX0, PH_HEX: begin
                if (i_cls.is_hex) begin
                    w_dig    = 1'b1;
                    w_b16    = 1'b1;
                    w_bump   = 1'b1;
                    n_phase  = PH_HEX;
                    w_fin    = i_cls.last;
                    w_fin_ok = 1'b1;
                end else begin
                    w_fin    = 1'b1;
                    w_fin_ok = (r_phase == PH_HEX);
                    n_phase  = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
    end

    // Magnitude and signed value are kept side by side so that no negation
    // follows the multiply-add on the way to the result.
    always_comb begin
        w_magx = {4'b0000, r_acc};
        w_dx   = {64'd0, i_cls.digit};
        w_mac  = w_b16 ? ((w_magx << 4) + w_dx)
                       : ((w_magx << 3) + (w_magx << 1) + w_dx);
        w_sdig = r_neg ? (64'd0 - {60'd0, i_cls.digit}) : {60'd0, i_cls.digit};
        w_smac = w_b16 ? ((r_sval << 4) + w_sdig)
                       : ((r_sval << 3) + (r_sval << 1) + w_sdig);
        w_cnt_inc = (r_cnt < CW'(MAX_LEN)) ? (r_cnt + 1'b1) : r_cnt;

        n_acc  = w_dig ? w_mac[63:0] : r_acc;
        n_sval = w_dig ? w_smac : r_sval;
        n_wrap = r_wrap || (w_dig && (w_mac[67:64] != 4'd0));
        n_cnt  = w_bump ? w_cnt_inc : r_cnt;
        n_neg  = r_neg || w_set_neg;

        w_cnt_ext = CWX'(n_cnt);
        n_out.ok       = w_fin_ok;
        n_out.value    = w_fin_ok ? n_sval : 64'd0;
        n_out.consumed = !w_fin_ok ? 8'd0
                       : (w_cnt_ext > CWX'(255)) ? 8'hFF : w_cnt_ext[7:0];
        n_out.overflow = w_fin_ok && n_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_sval  <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
            r_wrap  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_cls.last) begin
                    r_phase <= PH_START;
                    r_acc   <= '0;
                    r_sval  <= '0;
                    r_neg   <= 1'b0;
                    r_cnt   <= '0;
                    r_wrap  <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_acc   <= n_acc;
                    r_sval  <= n_sval;
                    r_neg   <= n_neg;
                    r_cnt   <= n_cnt;
                    r_wrap  <= n_wrap;
                end
            end
            if (o_pop && w_fin) begin
                r_ov  <= 1'b1;
                r_out <= n_out;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_dec_hex_integer_parser.sv =====
// Streaming signed decimal/hex integer parser: one character per cycle unless stalled.
// A deciding character passes through the queue, then the back end registers the result.
// Throughput: one character per cycle while no result is stalled, set by the back end's
// single multiply-add step; a four-entry queue absorbs up to four words while stalled.
// Reset (synchronous, active low) empties the queue, drops any pending result and
// returns the parser to the start of a string.
`default_nettype none

module signed_dec_hex_integer_parser #(
    parameter int unsigned MAX_LEN = sdhp_pkg::MAX_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire sdhp_pkg::t_in i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output sdhp_pkg::t_out     o_out_data,
    input  wire logic          i_out_stall
);

    logic           w_cls_valid;
    sdhp_pkg::t_cls w_cls;
    logic           w_pop;

    sdhp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cls_valid (w_cls_valid),
        .o_cls       (w_cls),
        .i_pop       (w_pop)
    );

    sdhp_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (w_cls_valid),
        .i_cls       (w_cls),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sdhp_checker.sv =====
// Port-level checks for the integer parser, bound to its top level.
// Depends on sdhp_pkg for the channel word types.
`default_nettype none

module sdhp_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire sdhp_pkg::t_out o_out_data,
    input wire logic           i_out_stall
);

    // The queue is empty right after reset, so input is taken at once.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A failed parse reports nothing but the failure.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |->
            o_out_data.value == 64'd0 && o_out_data.consumed == 8'd0 &&
            !o_out_data.overflow)
        else $error("failed result carries data");

    // A successful parse has taken at least one digit.
    a_ok_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ok |-> o_out_data.consumed != 8'd0)
        else $error("successful result consumed nothing");

endmodule

bind signed_dec_hex_integer_parser sdhp_checker u_sdhp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
